/* rtl/sdre_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdre_pkg
// shared types, sizes and character codes of the signed radix digit emitter
// ----------------------------------------------------------------------------
package sdre_pkg;

	// sizes
	localparam int MAX_SYMBOLS = 128;
	localparam int VALUE_BITS  = 32;
	localparam int CHAR_W      = 7;
	localparam int SYMBOL_W    = 8;
	localparam int FIELD_W     = 32;
	localparam int DIGIT_W     = $clog2(MAX_SYMBOLS);
	localparam int COUNT_W     = $clog2(MAX_SYMBOLS + 1);
	localparam int DEPTH_W     = $clog2(VALUE_BITS + 1);
	localparam int STEP_W      = $clog2(VALUE_BITS);

	// character codes
	localparam logic [SYMBOL_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [SYMBOL_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [SYMBOL_W-1:0] CH_SPACE = 8'h20;
	localparam logic [SYMBOL_W-1:0] CH_TILDE = 8'h7E;

	// item opcodes
	typedef enum logic [1:0] {
		MODE_CLEAR   = 2'd0,
		MODE_APPEND  = 2'd1,
		MODE_CONVERT = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SIGN,
		ST_READ,
		ST_LOAD
	} state_t;

	typedef struct packed {
		logic [1:0]                 mode;
		logic [SYMBOL_W-1:0]        symbol_in;
		logic signed [FIELD_W-1:0]  value;
	} in_t;

	typedef struct packed {
		logic [CHAR_W-1:0] char_out;
		logic              last;
	} out_t;

	typedef struct packed {
		logic bad;
		logic short_set;
	} alph_stat_t;

	typedef struct packed {
		logic done;
		logic quot_zero;
	} div_stat_t;

	typedef struct packed {
		logic last_slot;
		logic single;
	} stk_stat_t;

endpackage

/* rtl/signed_radix_digit_emitter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_radix_digit_emitter
// prints a signed value in the base set by a loaded digit alphabet
// ----------------------------------------------------------------------------
// usage
//   item channel (item_valid / item_stall / item): clear, append or convert.
//   a clear or append transfer produces nothing.
//   a convert transfer emits an optional '-' and then the digits, most
//   significant first, on the sym channel (sym_valid / sym_stall / sym), the
//   final character flagged by sym.last. a bad or short alphabet emits nothing.
// timing
//   one item in work at a time; item_stall is high while a conversion runs.
//   each digit costs one pass of the bit-serial divider; each emitted digit
//   then needs a stack pop and a registered alphabet read (ST_READ, then
//   ST_LOAD) into the output register; a '-' has its own state, ST_SIGN.
// reset
//   arst_n clears the alphabet count, the duplicate map and the bad flag;
//   the symbol store itself is not cleared.
// backpressure
//   sym_stall holds the output register; the sequencer waits for it and
//   picks up again without loss once the transfer completes.
// ----------------------------------------------------------------------------
module signed_radix_digit_emitter (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  sdre_pkg::in_t   item,
	output logic            sym_valid,
	input  logic            sym_stall,
	output sdre_pkg::out_t  sym
);
	import sdre_pkg::*;

	state_t                state_q;
	state_t                state_nxt;

	// item decode
	logic                  accept;
	logic                  do_clear;
	logic                  do_append;
	logic                  conv_go;
	logic [VALUE_BITS-1:0] v_w;
	logic [VALUE_BITS-1:0] mag_w;

	// datapath links
	alph_stat_t            astat;
	div_stat_t             dstat;
	stk_stat_t             sstat;
	logic [COUNT_W-1:0]    base;
	logic [CHAR_W-1:0]     alph_data;
	logic [VALUE_BITS-1:0] quotient;
	logic [DIGIT_W-1:0]    remainder;
	logic [DIGIT_W-1:0]    top_digit;

	// sequencer outputs
	logic                  div_start;
	logic [VALUE_BITS-1:0] div_dividend;
	logic                  stk_clear;
	logic                  stk_push;
	logic                  stk_pop;
	logic                  alph_rd;
	logic                  out_load;
	logic [CHAR_W-1:0]     out_char;
	logic                  out_last;

	// per-conversion flags
	logic                  neg_q;
	logic                  last_q;

	// output register
	logic                  out_valid_q;
	out_t                  out_q;
	logic                  out_free;

	assign accept    = item_valid && !item_stall;
	assign do_clear  = accept && (item.mode == MODE_CLEAR);
	assign do_append = accept && (item.mode == MODE_APPEND);
	assign conv_go   = accept && (item.mode == MODE_CONVERT) &&
		!astat.bad && !astat.short_set;

	// sign-extend to the working width, magnitude as unsigned (covers the minimum)
	assign v_w   = VALUE_BITS'(signed'(item.value));
	assign mag_w = v_w[VALUE_BITS-1] ? (~v_w + VALUE_BITS'(1)) : v_w;

	assign out_free = !out_valid_q || !sym_stall;

	sdre_alphabet u_alph (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (do_clear),
		.append  (do_append),
		.symbol  (item.symbol_in),
		.rd_en   (alph_rd),
		.rd_addr (top_digit),
		.rd_data (alph_data),
		.base    (base),
		.stat    (astat)
	);

	sdre_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.base      (base),
		.quotient  (quotient),
		.remainder (remainder),
		.stat      (dstat)
	);

	sdre_digit_stack u_stk (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (stk_clear),
		.push   (stk_push),
		.pop    (stk_pop),
		.din    (remainder),
		.top    (top_digit),
		.stat   (sstat)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (conv_go) begin
					state_nxt = ST_DIV;
				end
			end
			ST_DIV: begin
				// stop when the quotient runs out or the digit stack is full
				if (dstat.done && (dstat.quot_zero || sstat.last_slot)) begin
					state_nxt = neg_q ? ST_SIGN : ST_READ;
				end
			end
			ST_SIGN: begin
				if (out_free) begin
					state_nxt = ST_READ;
				end
			end
			ST_READ: begin
				state_nxt = ST_LOAD;
			end
			ST_LOAD: begin
				if (out_free) begin
					state_nxt = last_q ? ST_IDLE : ST_READ;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		item_stall   = 1'b1;
		div_start    = 1'b0;
		div_dividend = quotient;
		stk_clear    = 1'b0;
		stk_push     = 1'b0;
		stk_pop      = 1'b0;
		alph_rd      = 1'b0;
		out_load     = 1'b0;
		out_char     = alph_data;
		out_last     = last_q;
		unique case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				if (conv_go) begin
					div_start    = 1'b1;
					div_dividend = mag_w;
					stk_clear    = 1'b1;
				end
			end
			ST_DIV: begin
				if (dstat.done) begin
					stk_push = 1'b1;
					// next digit divides the quotient just produced
					if (!(dstat.quot_zero || sstat.last_slot)) begin
						div_start = 1'b1;
					end
				end
			end
			ST_SIGN: begin
				out_load = out_free;
				out_char = CHAR_W'(CH_MINUS);
				out_last = 1'b0;
			end
			ST_READ: begin
				stk_pop = 1'b1;
				alph_rd = 1'b1;
			end
			ST_LOAD: begin
				out_load = out_free;
			end
			default: begin
				item_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!sym_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (conv_go) begin
			neg_q <= v_w[VALUE_BITS-1];
		end
		// the popped digit is the final one when it was alone on the stack
		if (stk_pop) begin
			last_q <= sstat.single;
		end
		if (out_load) begin
			out_q.char_out <= out_char;
			out_q.last     <= out_last;
		end
	end

	assign sym_valid = out_valid_q;
	assign sym       = out_q;

endmodule

/* rtl/sdre_alphabet.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdre_alphabet
// digit alphabet store with duplicate map, symbol count and bad flag
// ----------------------------------------------------------------------------
module sdre_alphabet (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           clear,
	input  logic                           append,
	input  logic [sdre_pkg::SYMBOL_W-1:0]  symbol,
	input  logic                           rd_en,
	input  logic [sdre_pkg::DIGIT_W-1:0]   rd_addr,
	output logic [sdre_pkg::CHAR_W-1:0]    rd_data,
	output logic [sdre_pkg::COUNT_W-1:0]   base,
	output sdre_pkg::alph_stat_t           stat
);
	import sdre_pkg::*;

	localparam int CODES = 1 << CHAR_W;

	logic [CHAR_W-1:0]  mem [MAX_SYMBOLS];
	logic [CODES-1:0]   seen_q;
	logic [COUNT_W-1:0] count_q;
	logic               bad_q;
	logic               sym_ok;
	logic               dup;
	logic               full;
	logic               take;

	assign sym_ok = (symbol != CH_PLUS) && (symbol != CH_MINUS) &&
		(symbol > CH_SPACE) && (symbol < CH_TILDE);
	assign dup    = seen_q[symbol[CHAR_W-1:0]];
	assign full   = (count_q == COUNT_W'(MAX_SYMBOLS));
	assign take   = append && sym_ok && !dup && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= '0;
			count_q <= '0;
			bad_q   <= 1'b0;
		end else if (clear) begin
			seen_q  <= '0;
			count_q <= '0;
			bad_q   <= 1'b0;
		end else if (append) begin
			if (take) begin
				seen_q[symbol[CHAR_W-1:0]] <= 1'b1;
				count_q                    <= count_q + COUNT_W'(1);
			end else begin
				bad_q <= 1'b1;
			end
		end
	end

	// symbol store, registered read
	always_ff @(posedge clk) begin
		if (take) begin
			mem[count_q[DIGIT_W-1:0]] <= symbol[CHAR_W-1:0];
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	assign base           = count_q;
	assign stat.bad       = bad_q;
	assign stat.short_set = (count_q < COUNT_W'(2));

endmodule

/* rtl/sdre_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdre_divider
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module sdre_divider (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [sdre_pkg::VALUE_BITS-1:0] dividend,
	input  logic [sdre_pkg::COUNT_W-1:0]    base,
	output logic [sdre_pkg::VALUE_BITS-1:0] quotient,
	output logic [sdre_pkg::DIGIT_W-1:0]    remainder,
	output sdre_pkg::div_stat_t             stat
);
	import sdre_pkg::*;

	logic [VALUE_BITS-1:0] dvd_q;
	logic [DIGIT_W-1:0]    rem_q;
	logic [STEP_W-1:0]     step_q;
	logic                  busy_q;
	logic                  done_q;
	logic [DIGIT_W:0]      trial;
	logic [DIGIT_W:0]      base_x;
	logic [DIGIT_W:0]      diff;
	logic                  ge;
	logic [DIGIT_W-1:0]    rem_nxt;

	// partial remainder stays below base, so the shifted trial fits one extra bit
	assign trial   = {rem_q, dvd_q[VALUE_BITS-1]};
	assign base_x  = (DIGIT_W + 1)'(base);
	assign ge      = (trial >= base_x);
	assign diff    = trial - base_x;
	assign rem_nxt = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(VALUE_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[VALUE_BITS-2:0], ge};
			rem_q <= rem_nxt;
		end
	end

	assign quotient       = dvd_q;
	assign remainder      = rem_q;
	assign stat.done      = done_q;
	assign stat.quot_zero = (dvd_q == '0);

endmodule

/* rtl/sdre_digit_stack.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdre_digit_stack
// shift-register stack that turns low-first digits into high-first order
// ----------------------------------------------------------------------------
module sdre_digit_stack (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          clear,
	input  logic                          push,
	input  logic                          pop,
	input  logic [sdre_pkg::DIGIT_W-1:0]  din,
	output logic [sdre_pkg::DIGIT_W-1:0]  top,
	output sdre_pkg::stk_stat_t           stat
);
	import sdre_pkg::*;

	logic [DIGIT_W-1:0] stk_q [VALUE_BITS];
	logic [DEPTH_W-1:0] depth_q;

	always_ff @(posedge clk) begin
		if (push) begin
			stk_q[0] <= din;
			for (int i = 1; i < VALUE_BITS; i++) begin
				stk_q[i] <= stk_q[i-1];
			end
		end else if (pop) begin
			for (int i = 0; i < VALUE_BITS - 1; i++) begin
				stk_q[i] <= stk_q[i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
		end else if (clear) begin
			depth_q <= '0;
		end else if (push) begin
			depth_q <= depth_q + DEPTH_W'(1);
		end else if (pop) begin
			depth_q <= depth_q - DEPTH_W'(1);
		end
	end

	assign top            = stk_q[0];
	assign stat.last_slot = (depth_q == DEPTH_W'(VALUE_BITS - 1));
	assign stat.single    = (depth_q == DEPTH_W'(1));

endmodule

/* rtl/sdre_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdre_checker
// port-level checks of the signed radix digit emitter, bound to the top level
// ----------------------------------------------------------------------------
module sdre_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	input  logic            item_stall,
	input  sdre_pkg::in_t   item,
	input  logic            sym_valid,
	input  logic            sym_stall,
	input  sdre_pkg::out_t  sym
);
	import sdre_pkg::*;

	// a stalled character stays offered
	a_sym_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sym_valid && sym_stall |=> sym_valid)
		else $error("character dropped while stalled");

	// a stalled character keeps its value
	a_sym_stable: assert property (@(posedge clk) disable iff (!arst_n)
		sym_valid && sym_stall |=> $stable(sym))
		else $error("character changed while stalled");

	// clear and append never hold off the next item
	a_cfg_quick: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && (item.mode != MODE_CONVERT) |=> !item_stall)
		else $error("alphabet update blocked the item channel");

	// characters are only produced by a running conversion
	a_sym_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sym_valid) |-> $past(item_stall))
		else $error("character appeared outside a conversion");

	// the sign never ends a conversion
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		sym_valid |-> !((sym.char_out == CHAR_W'(CH_MINUS)) && sym.last))
		else $error("sign flagged as final character");

endmodule

bind signed_radix_digit_emitter sdre_checker u_sdre_checker (.*);
